>>> rtl/mmm_pkg.sv
// Shared constants, register codes and types of the motor mixing matrix.
package mmm_pkg;

	localparam int MAX_MOTORS = 6;
	localparam int NUM_ROWS   = 6;
	localparam int AXES       = 4;
	localparam int CMD_W      = 16;
	localparam int COEF_W     = 16;
	localparam int ROW_W      = COEF_W * AXES;
	localparam int MIDX_W     = 3;
	localparam int AXEN_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ROW_W;
	localparam int PROD_W     = CMD_W + COEF_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 14;
	localparam int RND_W      = SUM_W - FRAC_SHIFT;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [MIDX_W-1:0] MOTOR_COUNT_RST = MIDX_W'(4);
	localparam logic [AXEN_W-1:0] AXIS_ENABLE_RST = AXEN_W'(7);

	// column enable bits
	localparam int AXIS_ROLL  = 0;
	localparam int AXIS_PITCH = 1;
	localparam int AXIS_YAW   = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTOR_COUNT = 3'd0,
		REG_AXIS_ENABLE = 3'd1,
		REG_ROW_ZERO    = 3'd2,
		REG_ROW_ONE     = 3'd3,
		REG_ROW_TWO     = 3'd4,
		REG_ROW_THREE   = 3'd5,
		REG_ROW_FOUR    = 3'd6,
		REG_ROW_FIVE    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] thrust;
		logic signed [CMD_W-1:0] roll;
		logic signed [CMD_W-1:0] pitch;
		logic signed [CMD_W-1:0] yaw;
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [MIDX_W-1:0] last_idx;
	} job_t;

	typedef struct packed {
		logic [MIDX_W-1:0]               motor_count;
		logic [AXEN_W-1:0]               axis_enable;
		logic [NUM_ROWS-1:0][ROW_W-1:0]  rows;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

>>> rtl/mmm_ifs.sv
// Command and result channel interfaces of the motor mixing matrix.
interface mmm_cmd_if;
	import mmm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] thrust_cmd;
	logic signed [CMD_W-1:0] roll_cmd;
	logic signed [CMD_W-1:0] pitch_cmd;
	logic signed [CMD_W-1:0] yaw_cmd;

	modport source (output valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, input ready);
	modport sink (input valid, thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

interface mmm_res_if;
	import mmm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [MIDX_W-1:0]       motor_index;
	logic signed [CMD_W-1:0] motor_value;
	logic                    saturated;
	logic                    last_motor;

	modport source (output valid, motor_index, motor_value, saturated, last_motor,
		input ready);
	modport sink (input valid, motor_index, motor_value, saturated, last_motor,
		output ready);
endinterface

>>> rtl/mmm_regs.sv
// Configuration registers: motor count, column enables and coefficient rows.
module mmm_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mmm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mmm_pkg::cfg_t                    cfg
);
	import mmm_pkg::*;

	cfg_t              cfg_q;
	logic [MIDX_W-1:0] row_sel;

	assign row_sel = MIDX_W'(cfg_index - CFG_IDX_W'(REG_ROW_ZERO));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_count <= MOTOR_COUNT_RST;
			cfg_q.axis_enable <= AXIS_ENABLE_RST;
			cfg_q.rows        <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MOTOR_COUNT: begin
					cfg_q.motor_count <= cfg_data[MIDX_W-1:0];
				end
				REG_AXIS_ENABLE: begin
					cfg_q.axis_enable <= cfg_data[AXEN_W-1:0];
				end
				REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO,
				REG_ROW_THREE, REG_ROW_FOUR, REG_ROW_FIVE: begin
					cfg_q.rows[row_sel] <= cfg_data[ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/mmm_front.sv
// Front end: accepts command words, masks disabled columns, fixes the motor range.
module mmm_front (
	mmm_cmd_if.sink          cmd,
	input  mmm_pkg::cfg_t    cfg,
	input  logic             push_ready,
	output logic             push_valid,
	output mmm_pkg::job_t    push_job
);
	import mmm_pkg::*;

	logic [MIDX_W-1:0] last_idx;

	always_comb begin
		if (cfg.motor_count == '0) begin
			last_idx = '0;
		end else if (cfg.motor_count > MIDX_W'(MAX_MOTORS)) begin
			last_idx = MIDX_W'(MAX_MOTORS - 1);
		end else begin
			last_idx = cfg.motor_count - 1'b1;
		end
	end

	assign cmd.ready  = push_ready;
	assign push_valid = cmd.valid;

	always_comb begin
		push_job.cmd.thrust = cmd.thrust_cmd;
		push_job.cmd.roll   = cfg.axis_enable[AXIS_ROLL]  ? cmd.roll_cmd  : '0;
		push_job.cmd.pitch  = cfg.axis_enable[AXIS_PITCH] ? cmd.pitch_cmd : '0;
		push_job.cmd.yaw    = cfg.axis_enable[AXIS_YAW]   ? cmd.yaw_cmd   : '0;
		push_job.last_idx   = last_idx;
	end

endmodule

>>> rtl/mmm_queue.sv
// Short job queue between the front end and the mixing back end.
module mmm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  mmm_pkg::job_t    push_job,
	output logic             push_ready,
	output mmm_pkg::hs_t     pop_hs,
	input  logic             pop_ready,
	output mmm_pkg::job_t    pop_job
);
	import mmm_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push       = push_valid && push_ready;
	assign pop        = (cnt_q != '0) && pop_ready;

	assign pop_hs.valid = (cnt_q != '0);
	assign pop_hs.ready = pop_ready;
	assign pop_job      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

>>> rtl/mmm_back.sv
// Back end: walks the motors of the head job, multiplies, sums, rounds and clamps.
module mmm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mmm_pkg::cfg_t    cfg,
	input  mmm_pkg::hs_t     pop_hs,
	input  mmm_pkg::job_t    pop_job,
	output logic             pop_ready,
	mmm_res_if.source        res
);
	import mmm_pkg::*;

	logic                     adv;
	logic                     issue;
	logic                     at_last;
	logic [MIDX_W-1:0]        m_q;
	logic [ROW_W-1:0]         coef_row;
	logic signed [CMD_W-1:0]  cmd_a [AXES];

	logic                     vld_s1;
	logic [MIDX_W-1:0]        idx_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_s1 [AXES];

	logic                     vld_s2;
	logic [MIDX_W-1:0]        idx_s2;
	logic                     last_s2;
	logic signed [SUM_W-1:0]  sum_s2;

	logic signed [SUM_W-1:0]  biased;
	logic signed [RND_W-1:0]  rnd;
	logic                     ovf;
	logic signed [CMD_W-1:0]  clamped;

	logic                     out_vld_q;
	logic [MIDX_W-1:0]        out_idx_q;
	logic signed [CMD_W-1:0]  out_val_q;
	logic                     out_sat_q;
	logic                     out_last_q;

	// whole pipe moves together; the output register holds while the sink stalls
	assign adv       = !out_vld_q || res.ready;
	assign issue     = pop_hs.valid && adv;
	assign at_last   = (m_q == pop_job.last_idx);
	assign pop_ready = adv && at_last;

	assign coef_row = cfg.rows[m_q];
	assign cmd_a[0] = pop_job.cmd.thrust;
	assign cmd_a[1] = pop_job.cmd.roll;
	assign cmd_a[2] = pop_job.cmd.pitch;
	assign cmd_a[3] = pop_job.cmd.yaw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q       <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				m_q <= at_last ? '0 : m_q + 1'b1;
			end
			vld_s1    <= issue;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= m_q;
			last_s1 <= at_last;
			for (int a = 0; a < AXES; a++) begin
				prod_s1[a] <= $signed(coef_row[a*COEF_W +: COEF_W]) * cmd_a[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			sum_s2  <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1])
				+ SUM_W'(prod_s1[2]) + SUM_W'(prod_s1[3]);
		end
	end

	// round half up, drop the fraction, then clip to the command range
	assign biased  = sum_s2 + SUM_W'(1 << (FRAC_SHIFT - 1));
	assign rnd     = biased[SUM_W-1:FRAC_SHIFT];
	assign ovf     = !((&rnd[RND_W-1:CMD_W-1]) || !(|rnd[RND_W-1:CMD_W-1]));
	assign clamped = ovf ? {rnd[RND_W-1], {(CMD_W-1){~rnd[RND_W-1]}}} : rnd[CMD_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q  <= idx_s2;
			out_val_q  <= clamped;
			out_sat_q  <= ovf;
			out_last_q <= last_s2;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.motor_index = out_idx_q;
	assign res.motor_value = out_val_q;
	assign res.saturated   = out_sat_q;
	assign res.last_motor  = out_last_q;

endmodule

>>> rtl/motor_mixing_matrix_top.sv
// Top level of the motor mixing matrix: registers, front end, job queue, back end.
//
// Each accepted command word yields one result word per motor in use (1 to 6, from
// motor_count), in motor order, the final one flagged by last_motor. The back end
// runs one motor per cycle while the sink is not stalling, through a single row of
// four 16x16 multipliers, so a command occupies it until its last motor is issued
// and results stream at one word per cycle unless the sink stalls; each result passes
// the queue, then the product, sum and output registers. A two-entry queue lets the
// next command be taken while the current one is being mixed or its result is held
// by the sink. Write configuration only while no command is in flight.
module motor_mixing_matrix_top (
	input  logic                            clk,
	input  logic                            arst_n,
	mmm_cmd_if.sink                         cmd,
	mmm_res_if.source                       res,
	input  logic                            cfg_we,
	input  logic [mmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mmm_pkg::*;

	cfg_t cfg;
	logic push_valid;
	logic push_ready;
	job_t push_job;
	hs_t  pop_hs;
	logic pop_ready;
	job_t pop_job;

	mmm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mmm_front u_front (
		.cmd        (cmd),
		.cfg        (cfg),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	mmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_hs     (pop_hs),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	mmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_hs    (pop_hs),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.res       (res)
	);

	// a full queue always has a job at its head
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!push_ready |-> pop_hs.valid)
		else $error("queue full with no job at head");

	// motors of one command leave back to back in ascending order
	a_motor_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !res.last_motor |=>
		res.valid && (res.motor_index == MIDX_W'($past(res.motor_index) + 1'b1)))
		else $error("motor results out of order");

	// a clipped word sits at one of the range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.saturated |->
		(res.motor_value == 16'sh7FFF) || (res.motor_value == 16'sh8000))
		else $error("saturated word not at a limit");

	// the head job is only released on its final motor
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop_hs.valid && pop_ready |=> u_back.vld_s1 && u_back.last_s1)
		else $error("job released early");

endmodule
